// ===== hdl/fwt2_pkg.sv =====
// ----------------------------------------------------------------------------
// fwt2_pkg: shared types and constants of the 2D Fenwick tree core
// Request and result payloads, action and register codes, and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package fwt2_pkg;

    localparam int COORD_W    = 6;
    localparam int DELTA_W    = 32;
    localparam int RESULT_W   = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int WALK_W     = 8;
    localparam int TERM_COUNT = 4;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    localparam logic [1:0] TERM_FIRST = 2'd0;

    typedef struct packed {
        logic [1:0]                action;
        logic [COORD_W-1:0]        row_a;
        logic [COORD_W-1:0]        col_a;
        logic [COORD_W-1:0]        row_b;
        logic [COORD_W-1:0]        col_b;
        logic signed [DELTA_W-1:0] delta;
    } req_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] rect_sum;
        logic                       bad_corner;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_NEXT,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       walk_start;
        logic       walk_add;
        logic [1:0] term;
        logic       walk_step;
        logic       acc_clear;
        logic       out_load;
        logic       clear_step;
    } cmd_t;

    typedef struct packed {
        logic [1:0]            action;
        logic                  add_ok;
        logic                  query_bad;
        logic [TERM_COUNT-1:0] term_mask;
        logic                  walk_last;
        logic                  clear_last;
        logic                  out_busy;
    } stat_t;

endpackage

// ===== hdl/fenwick_tree_2d_point_add_range_sum_core.sv =====
// ----------------------------------------------------------------------------
// fenwick_tree_2d_point_add_range_sum_core: 2D binary indexed tree
// Point add of a signed Q16.16 delta and inclusive rectangle sum over a grid
// of rows_in_use by cols_in_use cells; clear of the whole store.
// ----------------------------------------------------------------------------
// One request is worked at a time; the tree memory has a single read port and
// serves one tree entry per cycle. A point add reads and rewrites each entry on
// its update walk (at most 49 at 64 by 64); a point add outside the grid is
// dropped without a walk. A rectangle query takes up to four prefix walks, each
// of popcount(row+1) * popcount(col+1) reads, and none for a bad corner.
// A clear sweeps all MAX_ROWS * MAX_COLS entries at one per cycle (4096 at the
// default size), and the same sweep runs after reset; no request is taken
// during a sweep, while configuration writes are. A finished result waits in
// an output register, and the next request is taken meanwhile.
module fenwick_tree_2d_point_add_range_sum_core #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int SUM_WIDTH = 48
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fwt2_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fwt2_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  fwt2_pkg::req_t                  req_data,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output fwt2_pkg::rsp_t                  rsp_data
);
    import fwt2_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fwt2_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fwt2_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (req_data),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== hdl/fwt2_ctrl.sv =====
// ----------------------------------------------------------------------------
// fwt2_ctrl: sequencer of the 2D Fenwick tree core
// Accepts requests, runs the add walk, up to four query walks or the clearing
// sweep, and hands finished query results to the output register.
// ----------------------------------------------------------------------------
module fwt2_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  fwt2_pkg::stat_t stat,
    output fwt2_pkg::cmd_t  cmd
);
    import fwt2_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] term_reg, term_next;
    logic       next_found;
    logic [1:0] next_term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            term_reg  <= TERM_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

    always_comb
    begin
        next_found = 1'b0;
        next_term  = term_reg;
        for (int t = TERM_COUNT - 1; t >= 1; t--)
        begin
            if (t > int'(term_reg) && stat.term_mask[t])
            begin
                next_found = 1'b1;
                next_term  = 2'(t);
            end
        end
    end

    always_comb
    begin
        cmd        = '0;
        req_ready  = 1'b0;
        state_next = state_reg;
        term_next  = term_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.action)
                    ACT_ADD:
                    begin
                        if (stat.add_ok)
                        begin
                            cmd.walk_start = 1'b1;
                            cmd.walk_add   = 1'b1;
                            state_next     = S_WALK;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    ACT_QUERY:
                    begin
                        cmd.acc_clear = 1'b1;
                        if (stat.query_bad)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.walk_start = 1'b1;
                            cmd.term       = TERM_FIRST;
                            term_next      = TERM_FIRST;
                            state_next     = S_WALK;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        state_next = S_CLEAR;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last)
                begin
                    if (stat.action != ACT_ADD && next_found)
                    begin
                        term_next  = next_term;
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_NEXT:
            begin
                cmd.walk_start = 1'b1;
                cmd.term       = term_reg;
                state_next     = S_WALK;
            end
            S_DRAIN:
            begin
                state_next = (stat.action == ACT_ADD) ? S_IDLE : S_FINISH;
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/fwt2_datapath.sv =====
// ----------------------------------------------------------------------------
// fwt2_datapath: storage and arithmetic of the 2D Fenwick tree core
// Size registers, request register, index walk counters, tree memory with
// registered read, read-modify-write for adds, query accumulator, and the
// result register.
// ----------------------------------------------------------------------------
module fwt2_datapath #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int SUM_WIDTH = 48
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [fwt2_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fwt2_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  fwt2_pkg::req_t                     req_data,
    input  logic                               rsp_ready,
    output logic                               rsp_valid,
    output fwt2_pkg::rsp_t                     rsp_data,
    input  fwt2_pkg::cmd_t                     cmd,
    output fwt2_pkg::stat_t                    stat
);
    import fwt2_pkg::*;

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [CFG_DATA_W-1:0] ROWS_RESET =
        CFG_DATA_W'((MAX_ROWS < 64) ? MAX_ROWS : 64);
    localparam logic [CFG_DATA_W-1:0] COLS_RESET =
        CFG_DATA_W'((MAX_COLS < 64) ? MAX_COLS : 64);

    function automatic logic [CFG_DATA_W-1:0] limit_size(
        input logic [CFG_DATA_W-1:0] v,
        input int                    max_size
    );
        logic [CFG_DATA_W-1:0] s;
        s = v;
        if (s == '0)
            s = CFG_DATA_W'(1);
        if (int'(s) > max_size)
            s = CFG_DATA_W'(max_size);
        return s;
    endfunction

    logic [SUM_WIDTH-1:0] tree_mem [DEPTH];

    logic [CFG_DATA_W-1:0] rows_reg, cols_reg;
    req_t                  req_reg;
    logic [WALK_W-1:0]     wi_reg, wi_next;
    logic [WALK_W-1:0]     wj_reg, wj_next;
    logic [WALK_W-1:0]     cstart_reg;
    logic                  neg_reg;
    logic                  wadd_reg;
    logic                  rd_valid_reg;
    logic                  rd_add_reg;
    logic                  rd_neg_reg;
    logic [ADDR_W-1:0]     rd_addr_reg;
    logic [SUM_WIDTH-1:0]  rd_data_reg;
    logic [SUM_WIDTH-1:0]  acc_reg;
    logic [ADDR_W-1:0]     clear_addr_reg;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;

    logic [WALK_W-1:0]     ra_w, ca_w, rb_w, cb_w;
    logic [WALK_W-1:0]     start_i, start_j;
    logic                  start_neg;
    logic [WALK_W-1:0]     lb_i, lb_j, ni_raw, nj_raw;
    logic                  row_wrap, walk_last;
    logic [ADDR_W-1:0]     row_idx, col_idx, walk_addr;
    logic                  add_ok, query_bad;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [SUM_WIDTH-1:0]  mem_wdata;
    logic [SUM_WIDTH-1:0]  delta_ext;
    logic [63:0]           acc_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROWS: rows_reg <= limit_size(cfg_data, MAX_ROWS);
                CFG_COLS: cols_reg <= limit_size(cfg_data, MAX_COLS);
                default:  rows_reg <= rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= req_data;
    end

    always_comb
    begin
        ra_w = WALK_W'(req_reg.row_a);
        ca_w = WALK_W'(req_reg.col_a);
        rb_w = WALK_W'(req_reg.row_b);
        cb_w = WALK_W'(req_reg.col_b);

        add_ok    = (CFG_DATA_W'(req_reg.row_a) < rows_reg) &&
                    (CFG_DATA_W'(req_reg.col_a) < cols_reg);
        query_bad = (CFG_DATA_W'(req_reg.row_a) >= rows_reg) ||
                    (CFG_DATA_W'(req_reg.row_b) >= rows_reg) ||
                    (CFG_DATA_W'(req_reg.col_a) >= cols_reg) ||
                    (CFG_DATA_W'(req_reg.col_b) >= cols_reg);

        if (cmd.walk_add)
        begin
            start_i   = ra_w + WALK_W'(1);
            start_j   = ca_w + WALK_W'(1);
            start_neg = 1'b0;
        end
        else
        begin
            start_i   = cmd.term[0] ? ra_w : rb_w + WALK_W'(1);
            start_j   = cmd.term[1] ? ca_w : cb_w + WALK_W'(1);
            start_neg = cmd.term[0] ^ cmd.term[1];
        end

        lb_i = wi_reg & (~wi_reg + WALK_W'(1));
        lb_j = wj_reg & (~wj_reg + WALK_W'(1));
        if (wadd_reg)
        begin
            nj_raw    = wj_reg + lb_j;
            ni_raw    = wi_reg + lb_i;
            row_wrap  = nj_raw > WALK_W'(cols_reg);
            walk_last = row_wrap && (ni_raw > WALK_W'(rows_reg));
        end
        else
        begin
            nj_raw    = wj_reg - lb_j;
            ni_raw    = wi_reg - lb_i;
            row_wrap  = nj_raw == '0;
            walk_last = row_wrap && (ni_raw == '0);
        end

        if (cmd.walk_start)
        begin
            wi_next = start_i;
            wj_next = start_j;
        end
        else if (cmd.walk_step && row_wrap)
        begin
            wi_next = ni_raw;
            wj_next = cstart_reg;
        end
        else if (cmd.walk_step)
        begin
            wi_next = wi_reg;
            wj_next = nj_raw;
        end
        else
        begin
            wi_next = wi_reg;
            wj_next = wj_reg;
        end

        row_idx   = ADDR_W'(wi_reg - WALK_W'(1));
        col_idx   = ADDR_W'(wj_reg - WALK_W'(1));
        walk_addr = row_idx * ADDR_W'(MAX_COLS) + col_idx;
    end

    always_ff @(posedge clk)
    begin
        wi_reg <= wi_next;
        wj_reg <= wj_next;
        if (cmd.walk_start)
        begin
            cstart_reg <= start_j;
            neg_reg    <= start_neg;
            wadd_reg   <= cmd.walk_add;
        end
    end

    always_comb
    begin
        delta_ext = SUM_WIDTH'(req_reg.delta);
        mem_we    = cmd.clear_step || (rd_valid_reg && rd_add_reg);
        mem_waddr = cmd.clear_step ? clear_addr_reg : rd_addr_reg;
        mem_wdata = cmd.clear_step ? '0 : rd_data_reg + delta_ext;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            tree_mem[mem_waddr] <= mem_wdata;
        if (cmd.walk_step)
            rd_data_reg <= tree_mem[walk_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            clear_addr_reg <= '0;
        end
        else
        begin
            rd_valid_reg <= cmd.walk_step;
            if (cmd.clear_step)
            begin
                if (clear_addr_reg == ADDR_W'(DEPTH - 1))
                    clear_addr_reg <= '0;
                else
                    clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_step)
        begin
            rd_addr_reg <= walk_addr;
            rd_add_reg  <= wadd_reg;
            rd_neg_reg  <= neg_reg;
        end
        if (cmd.acc_clear)
            acc_reg <= '0;
        else if (rd_valid_reg && !rd_add_reg)
            acc_reg <= rd_neg_reg ? acc_reg - rd_data_reg : acc_reg + rd_data_reg;
    end

    assign acc_wide = 64'(acc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.out_load)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_reg.rect_sum   <= query_bad ? '0 : acc_wide[RESULT_W-1:0];
            rsp_reg.bad_corner <= query_bad;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    always_comb
    begin
        stat.action       = req_reg.action;
        stat.add_ok       = add_ok;
        stat.query_bad    = query_bad;
        stat.term_mask[0] = 1'b1;
        stat.term_mask[1] = req_reg.row_a != '0;
        stat.term_mask[2] = req_reg.col_a != '0;
        stat.term_mask[3] = (req_reg.row_a != '0) && (req_reg.col_a != '0);
        stat.walk_last    = walk_last;
        stat.clear_last   = clear_addr_reg == ADDR_W'(DEPTH - 1);
        stat.out_busy     = rsp_valid_reg && !rsp_ready;
    end

endmodule

// ===== tb/fwt2_checker.sv =====
// ----------------------------------------------------------------------------
// fwt2_checker: response checker of the 2D Fenwick tree core
// Tracks register writes and accepted requests, keeps its own copy of the tree
// memory and the grid size, predicts every rectangle sum and compares each
// accepted response, field by field, with the oldest prediction in line.
// ----------------------------------------------------------------------------
module fwt2_checker #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int SUM_WIDTH = 48
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fwt2_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fwt2_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            req_valid,
    input  logic                            req_ready,
    input  fwt2_pkg::req_t                  req_data,
    input  logic                            rsp_valid,
    input  logic                            rsp_ready,
    input  fwt2_pkg::rsp_t                  rsp_data,
    output int                              pending,
    output int                              mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import fwt2_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;

    logic [SUM_WIDTH-1:0] tree_mem [CELLS];
    int unsigned          rows_used;
    int unsigned          cols_used;
    rsp_t                 sums_due [$];
    rsp_t                 want;

    function automatic int unsigned low_one(input int unsigned v);
        return v & (~v + 1);
    endfunction

    function automatic int unsigned fit_size(input logic [CFG_DATA_W-1:0] v,
                                             input int unsigned cap);
        int unsigned s;
        s = v;
        if (s == 0)
            s = 1;
        if (s > cap)
            s = cap;
        return s;
    endfunction

    function automatic void tree_add(input int unsigned r, input int unsigned c,
                                     input logic [SUM_WIDTH-1:0] amount);
        int unsigned i;
        int unsigned j;
        for (i = r + 1; i <= rows_used; i += low_one(i))
            for (j = c + 1; j <= cols_used; j += low_one(j))
                tree_mem[(i - 1) * MAX_COLS + (j - 1)] += amount;
    endfunction

    function automatic logic [SUM_WIDTH-1:0] prefix_sum(input int unsigned r,
                                                        input int unsigned c);
        logic [SUM_WIDTH-1:0] s;
        int unsigned          i;
        int unsigned          j;
        s = '0;
        for (i = r + 1; i > 0; i -= low_one(i))
            for (j = c + 1; j > 0; j -= low_one(j))
                s += tree_mem[(i - 1) * MAX_COLS + (j - 1)];
        return s;
    endfunction

    function automatic rsp_t rect_query(input req_t q);
        rsp_t                 res;
        logic [SUM_WIDTH-1:0] s;
        int unsigned          ra;
        int unsigned          ca;
        int unsigned          rb;
        int unsigned          cb;
        res = '0;
        ra  = q.row_a;
        ca  = q.col_a;
        rb  = q.row_b;
        cb  = q.col_b;
        if (ra >= rows_used || rb >= rows_used || ca >= cols_used || cb >= cols_used)
        begin
            res.bad_corner = 1'b1;
            return res;
        end
        s = prefix_sum(rb, cb);
        if (ra > 0)
            s -= prefix_sum(ra - 1, cb);
        if (ca > 0)
            s -= prefix_sum(rb, ca - 1);
        if (ra > 0 && ca > 0)
            s += prefix_sum(ra - 1, ca - 1);
        res.rect_sum = RESULT_W'(s);
        return res;
    endfunction

    function automatic void wipe_tree();
        for (int k = 0; k < CELLS; k++)
            tree_mem[k] = '0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_tree();
            rows_used = fit_size(7'd64, MAX_ROWS);
            cols_used = fit_size(7'd64, MAX_COLS);
            sums_due.delete();
            pending    = 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROWS: rows_used = fit_size(cfg_data, MAX_ROWS);
                    CFG_COLS: cols_used = fit_size(cfg_data, MAX_COLS);
                    default: ;
                endcase
            end
            if (req_valid && req_ready)
            begin
                case (req_data.action)
                    ACT_ADD:
                        if (req_data.row_a < rows_used && req_data.col_a < cols_used)
                            tree_add(req_data.row_a, req_data.col_a,
                                     SUM_WIDTH'(signed'(req_data.delta)));
                    ACT_QUERY: sums_due.push_back(rect_query(req_data));
                    ACT_CLEAR: wipe_tree();
                    default: ;
                endcase
            end
            if (rsp_valid && rsp_ready)
            begin
                if (sums_due.size() == 0)
                begin
                    $error("rect_sum: no query waiting, got %0d bad_corner %0b",
                           $signed(rsp_data.rect_sum), rsp_data.bad_corner);
                    mismatches++;
                end
                else
                begin
                    want = sums_due.pop_front();
                    if (rsp_data.rect_sum !== want.rect_sum)
                    begin
                        $error("rect_sum: expected %0d, got %0d",
                               $signed(want.rect_sum), $signed(rsp_data.rect_sum));
                        mismatches++;
                    end
                    if (rsp_data.bad_corner !== want.bad_corner)
                    begin
                        $error("bad_corner: expected %0b, got %0b",
                               want.bad_corner, rsp_data.bad_corner);
                        mismatches++;
                    end
                end
            end
            pending = sums_due.size();
        end
    end

endmodule

// ===== tb/tb_fenwick_tree_2d_point_add_range_sum_core.sv =====
// ----------------------------------------------------------------------------
// tb_fenwick_tree_2d_point_add_range_sum_core: regression of the 2D Fenwick core
// Directed point adds, rectangle queries and clears at the grid extremes, then
// random phases over several grid sizes with bursty requests and a stalling
// response side; the checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module tb_fenwick_tree_2d_point_add_range_sum_core;
    timeunit 1ns;
    timeprecision 1ps;

    import fwt2_pkg::*;

    localparam int MAX_ROWS       = 64;
    localparam int MAX_COLS       = 64;
    localparam int SUM_WIDTH      = 48;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 200;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req_data  = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp_data;
    int                    pending;
    int                    mismatches;

    int unsigned rows_lim    = 64;
    int unsigned cols_lim    = 64;
    int          burst_left  = 0;
    int          stall_span  = 0;
    int          stall_mode  = 0;
    int          idle_cycles = 0;

    fenwick_tree_2d_point_add_range_sum_core #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .SUM_WIDTH (SUM_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    fwt2_checker #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_data   (rsp_data),
        .pending    (pending),
        .mismatches (mismatches)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(16, 400);
        end
        stall_span--;
        case (stall_mode)
            0, 1:    rsp_ready = 1'b1;
            2:       rsp_ready = 1'($urandom_range(0, 1));
            default: rsp_ready = ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic req_t pack_req(input logic [1:0] act, input int unsigned ra,
                                      input int unsigned ca, input int unsigned rb,
                                      input int unsigned cb, input logic [31:0] d);
        req_t r;
        r.action = act;
        r.row_a  = COORD_W'(ra);
        r.col_a  = COORD_W'(ca);
        r.row_b  = COORD_W'(rb);
        r.col_b  = COORD_W'(cb);
        r.delta  = d;
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned lim);
        if ($urandom_range(0, 9) == 0)
            return COORD_W'($urandom_range(0, 63));
        return COORD_W'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [31:0] pick_delta();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 511)) - 32'd256;
            2:
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            default: return (32'($urandom_range(0, 200)) - 32'd100) << 16;
        endcase
    endfunction

    function automatic req_t random_req();
        req_t               r;
        int unsigned        roll;
        logic [COORD_W-1:0] tmp;
        roll = $urandom_range(0, 199);
        r    = pack_req(ACT_QUERY, pick_coord(rows_lim), pick_coord(cols_lim),
                        pick_coord(rows_lim), pick_coord(cols_lim), pick_delta());
        if (roll < 4)
        begin
            r        = pack_req(ACT_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                                $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
        end
        else if (roll < 5)
            r.action = ACT_CLEAR;
        else if (roll < 104)
            r.action = ACT_ADD;
        else
        begin
            if ($urandom_range(0, 3) != 0 && r.row_a > r.row_b)
            begin
                tmp     = r.row_a;
                r.row_a = r.row_b;
                r.row_b = tmp;
            end
            if ($urandom_range(0, 3) != 0 && r.col_a > r.col_b)
            begin
                tmp     = r.col_a;
                r.col_a = r.col_b;
                r.col_b = tmp;
            end
        end
        return r;
    endfunction

    task automatic issue(input req_t r);
        req_data  = r;
        req_valid = 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 25)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic wait_results(input bit quiet_core);
        req_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        if (quiet_core)
        begin
            repeat (DRAIN_CYCLES) @(negedge clk);
            while (!req_ready)
                @(negedge clk);
        end
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] v);
        int unsigned s;
        s = (v == 0) ? 1 : v;
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        @(negedge clk);
        cfg_we    = 1'b0;
        if (idx == CFG_ROWS)
            rows_lim = (s > MAX_ROWS) ? MAX_ROWS : s;
        else
            cols_lim = (s > MAX_COLS) ? MAX_COLS : s;
    endtask

    initial
    begin
        req_t r;
        int   n;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        issue(pack_req(ACT_QUERY, 0, 0, 63, 63, 32'h0));
        issue(pack_req(ACT_ADD, 0, 0, 0, 0, 32'h7FFF_FFFF));
        issue(pack_req(ACT_ADD, 63, 63, 0, 0, 32'h8000_0000));
        issue(pack_req(ACT_ADD, 0, 63, 0, 0, 32'hFFFF_FFFF));
        issue(pack_req(ACT_ADD, 63, 0, 0, 0, 32'h0001_0000));
        issue(pack_req(ACT_ADD, 42, 21, 0, 0, 32'h5555_AAAA));
        issue(pack_req(ACT_QUERY, 0, 0, 63, 63, 32'h0));
        issue(pack_req(ACT_QUERY, 63, 63, 63, 63, 32'h0));
        issue(pack_req(ACT_QUERY, 0, 0, 0, 0, 32'h0));
        issue(pack_req(ACT_QUERY, 1, 1, 62, 62, 32'h0));
        issue(pack_req(ACT_QUERY, 40, 50, 10, 20, 32'h0));
        issue(pack_req(ACT_UNUSED, 63, 63, 63, 63, 32'hFFFF_FFFF));
        issue(pack_req(ACT_CLEAR, 0, 0, 0, 0, 32'h0));
        issue(pack_req(ACT_QUERY, 0, 0, 63, 63, 32'h0));
        wait_results(1'b1);

        put_reg(CFG_ROWS, 7'd0);
        put_reg(CFG_COLS, 7'd127);
        issue(pack_req(ACT_ADD, 0, 63, 0, 0, 32'h1234_5678));
        issue(pack_req(ACT_ADD, 1, 0, 0, 0, 32'h0000_1000));
        issue(pack_req(ACT_QUERY, 0, 0, 0, 63, 32'h0));
        issue(pack_req(ACT_QUERY, 0, 10, 1, 20, 32'h0));
        issue(pack_req(ACT_QUERY, 0, 63, 0, 0, 32'h0));
        wait_results(1'b1);

        put_reg(CFG_COLS, 7'd5);
        issue(pack_req(ACT_ADD, 0, 5, 0, 0, 32'h0002_0000));
        issue(pack_req(ACT_QUERY, 0, 0, 0, 5, 32'h0));
        issue(pack_req(ACT_QUERY, 0, 0, 0, 4, 32'h0));

        for (int p = 0; p < PHASES; p++)
        begin
            wait_results(1'b1);
            case (p)
                0:
                begin
                    put_reg(CFG_ROWS, 7'd64);
                    put_reg(CFG_COLS, 7'd64);
                end
                1:
                begin
                    put_reg(CFG_ROWS, 7'd0);
                    put_reg(CFG_COLS, 7'd1);
                end
                2:
                begin
                    put_reg(CFG_ROWS, 7'd2);
                    put_reg(CFG_COLS, 7'd64);
                end
                3:
                begin
                    put_reg(CFG_ROWS, 7'd127);
                    put_reg(CFG_COLS, 7'd3);
                end
                4:
                begin
                    put_reg(CFG_ROWS, 7'd33);
                    put_reg(CFG_COLS, 7'd17);
                end
                default:
                begin
                    put_reg(CFG_ROWS, CFG_DATA_W'($urandom_range(0, 127)));
                    put_reg(CFG_COLS, CFG_DATA_W'($urandom_range(0, 127)));
                end
            endcase
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                r = random_req();
                issue(r);
                if (r.action != ACT_UNUSED)
                    n++;
                if ($urandom_range(0, 99) == 0)
                    wait_results(1'b0);
            end
        end

        wait_results(1'b0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== fenwick_tree_2d_point_add_range_sum_core.f =====
hdl/fwt2_pkg.sv
hdl/fwt2_ctrl.sv
hdl/fwt2_datapath.sv
hdl/fenwick_tree_2d_point_add_range_sum_core.sv
tb/fwt2_checker.sv
tb/tb_fenwick_tree_2d_point_add_range_sum_core.sv
